// ===== rtl/bed_pkg.sv =====
// Package for the band energy hysteresis detector.
// Holds field widths, register indexes, reset values and the result item type.
// No dependencies.
package bed_pkg;

  // Default frame geometry
  localparam int FrameBinsDef = 256;
  localparam int BandFirstDef = 64;
  localparam int BandEndDef   = 128;

  // Width used to compare a bin index with the frame geometry (up to 8191)
  localparam int IdxCmpW = 13;

  // Field widths
  localparam int BinIdxW  = 8;
  localparam int PowerW   = 32;
  localparam int ThrW     = 38;
  localparam int LimitW   = 32;
  localparam int AlphaW   = 16;
  localparam int FramesW  = 8;
  localparam int WarmW    = 9;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 38;

  // State widths
  localparam int LowSmpW  = 32;
  localparam int HighSumW = 38;
  localparam int LowAvgW  = 48;
  localparam int HighAvgW = 54;

  // Stream widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 8;

  // Result queue
  localparam int ResDepth = 8;
  localparam int ResPtrW  = 3;
  localparam int ResCntW  = 4;

  // Register reset values
  localparam logic [LimitW-1:0]  LowLimitRst = '1;
  localparam logic [AlphaW-1:0]  AlphaRst    = 16'd6554;
  localparam logic               WarmEnRst   = 1'b1;
  localparam logic [FramesW-1:0] FramesRst   = 8'd3;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgOnThr    = 3'd0,
    CfgOffThr   = 3'd1,
    CfgLowLimit = 3'd2,
    CfgAlpha    = 3'd3,
    CfgWarmEn   = 3'd4,
    CfgWarmCnt  = 3'd5
  } bed_cfg_e;

  // Transition codes
  typedef enum logic [1:0] {
    TransNone = 2'd0,
    TransOn   = 2'd1,
    TransOff  = 2'd2
  } bed_trans_e;

  // One result item
  typedef struct packed {
    bed_trans_e trans;
    logic       on;
  } bed_res_t;

  localparam int ResW = $bits(bed_res_t);

endpackage

// ===== rtl/bed_ewma.sv =====
// Exponential moving average for one band, one frame value per item.
// Two stages: scale the frame value by alpha, then fold it into the average.
// Depends on bed_pkg.
module bed_ewma import bed_pkg::*; #(
  parameter int SmpW = LowSmpW,
  parameter int AvgW = LowAvgW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              smp_vld_i,
  input  logic [SmpW-1:0]   smp_i,
  input  logic [AlphaW-1:0] alpha_i,
  output logic              avg_vld_o,
  output logic [AvgW-1:0]   avg_o
);

  localparam int ProdW = SmpW + AlphaW;
  localparam int DecW  = AvgW + AlphaW;

  logic             prod_vld_q;
  logic [ProdW-1:0] prod_q;
  logic             avg_vld_q;
  logic [AvgW-1:0]  avg_q, avg_d;
  logic [DecW-1:0]  dec_prod;
  logic [DecW:0]    dec_round;
  logic [AvgW-1:0]  dec_ceil;
  logic [AvgW:0]    avg_sum;

  // Scale the new frame value by alpha
  always_ff @(posedge clk_i) begin
    if (smp_vld_i) begin
      prod_q <= ProdW'(smp_i) * ProdW'(alpha_i);
    end
  end

  // avg - ceil(avg * alpha / 2^16) equals floor(avg * (1 - alpha))
  always_comb begin
    dec_prod  = DecW'(avg_q) * DecW'(alpha_i);
    dec_round = (DecW + 1)'(dec_prod) + (DecW + 1)'({AlphaW{1'b1}});
    dec_ceil  = dec_round[AlphaW +: AvgW];
    avg_sum   = (AvgW + 1)'(avg_q) - (AvgW + 1)'(dec_ceil) + (AvgW + 1)'(prod_q);
    avg_d     = avg_sum[AvgW-1:0];
  end

  // Hold the average between frames
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      avg_vld_q  <= 1'b0;
      avg_q      <= '0;
    end else begin
      prod_vld_q <= smp_vld_i;
      avg_vld_q  <= prod_vld_q;
      if (prod_vld_q) begin
        avg_q <= avg_d;
      end
    end
  end

  assign avg_vld_o = avg_vld_q;
  assign avg_o     = avg_q;

endmodule

// ===== rtl/band_energy_hysteresis_detector_top.sv =====
// Top level of the band energy hysteresis detector.
// Accumulates band powers, averages them per frame and runs the on/off detector.
// Depends on bed_pkg and bed_ewma.
//
//   channel    | direction | item
//   s_axis     | in        | one spectrum bin: tdata = bin_index, bin_power; tlast = last_bin
//   m_axis     | out       | one status per frame: tdata = detector_on, transition
//   cfg        | in        | register write, no read-back
//
// One bin is taken every cycle while the result queue has room. A frame's status
// passes through the frame value register, the alpha multiply, the average
// update loop and the result queue. Results wait in an eight-entry queue;
// the input stalls only when that queue could fill. Reset is asynchronous,
// active low, and needs no clearing pass.
module band_energy_hysteresis_detector_top import bed_pkg::*; #(
  parameter int FRAME_BINS = FrameBinsDef,
  parameter int BAND_FIRST = BandFirstDef,
  parameter int BAND_END   = BandEndDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // bin_index [7:0], bin_power [39:8]
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // detector_on [0], transition [2:1], zeros [7:3]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [ThrW-1:0]    on_thr_q, off_thr_q;
  logic [LimitW-1:0]  low_limit_q;
  logic [AlphaW-1:0]  alpha_q;
  logic               warm_en_q;
  logic [FramesW-1:0] warm_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_thr_q    <= '0;
      off_thr_q   <= '0;
      low_limit_q <= LowLimitRst;
      alpha_q     <= AlphaRst;
      warm_en_q   <= WarmEnRst;
      warm_cnt_q  <= FramesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOnThr:    on_thr_q    <= cfg_data_i[ThrW-1:0];
        CfgOffThr:   off_thr_q   <= cfg_data_i[ThrW-1:0];
        CfgLowLimit: low_limit_q <= cfg_data_i[LimitW-1:0];
        CfgAlpha:    alpha_q     <= cfg_data_i[AlphaW-1:0];
        CfgWarmEn:   warm_en_q   <= cfg_data_i[0];
        CfgWarmCnt:  warm_cnt_q  <= cfg_data_i[FramesW-1:0];
        default:     ;
      endcase
    end
  end

  // Input item fields
  logic [BinIdxW-1:0] bin_index;
  logic [PowerW-1:0]  bin_power;
  logic               accept;

  assign bin_index = s_axis_tdata[BinIdxW-1:0];
  assign bin_power = s_axis_tdata[BinIdxW +: PowerW];
  assign accept    = s_axis_tvalid && s_axis_tready;

  // Classify the bin and accumulate the bands
  logic [IdxCmpW-1:0]  idx_ext;
  logic                in_frame, is_low, is_band;
  logic [LowSmpW-1:0]  low_smp_q, low_next;
  logic [HighSumW-1:0] high_sum_q, high_next, sum_sat;
  logic [HighSumW:0]   sum_wide;

  always_comb begin
    idx_ext   = IdxCmpW'(bin_index);
    in_frame  = idx_ext < IdxCmpW'(FRAME_BINS);
    is_low    = in_frame && (idx_ext == IdxCmpW'(1));
    is_band   = in_frame && (idx_ext >= IdxCmpW'(BAND_FIRST)) &&
                (idx_ext < IdxCmpW'(BAND_END));
    sum_wide  = (HighSumW + 1)'(high_sum_q) + (HighSumW + 1)'(bin_power);
    sum_sat   = sum_wide[HighSumW] ? '1 : sum_wide[HighSumW-1:0];
    low_next  = is_low ? bin_power : low_smp_q;
    high_next = is_band ? sum_sat : high_sum_q;
  end

  // Hand the finished frame values on and clear for the next frame
  logic                frm_vld_q;
  logic [LowSmpW-1:0]  frm_low_q;
  logic [HighSumW-1:0] frm_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_smp_q  <= '0;
      high_sum_q <= '0;
      frm_vld_q  <= 1'b0;
    end else begin
      frm_vld_q <= accept && s_axis_tlast;
      if (accept) begin
        if (s_axis_tlast) begin
          low_smp_q  <= '0;
          high_sum_q <= '0;
        end else begin
          low_smp_q  <= low_next;
          high_sum_q <= high_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast) begin
      frm_low_q  <= low_next;
      frm_high_q <= high_next;
    end
  end

  // Moving averages
  logic                avg_vld, avg_vld_hi;
  logic [LowAvgW-1:0]  low_avg;
  logic [HighAvgW-1:0] high_avg;

  bed_ewma #(
    .SmpW (LowSmpW),
    .AvgW (LowAvgW)
  ) u_low_ewma (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp_vld_i (frm_vld_q),
    .smp_i     (frm_low_q),
    .alpha_i   (alpha_q),
    .avg_vld_o (avg_vld),
    .avg_o     (low_avg)
  );

  bed_ewma #(
    .SmpW (HighSumW),
    .AvgW (HighAvgW)
  ) u_high_ewma (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp_vld_i (frm_vld_q),
    .smp_i     (frm_high_q),
    .alpha_i   (alpha_q),
    .avg_vld_o (avg_vld_hi),
    .avg_o     (high_avg)
  );

  // Hysteresis detector
  logic                    is_on_q, is_on_d;
  logic signed [WarmW-1:0] warm_q, warm_d, warm_rld;
  logic                    pass, go;
  bed_res_t                res_d;

  always_comb begin
    warm_rld = $signed(WarmW'(warm_cnt_q));
    pass     = (high_avg > {on_thr_q, {AlphaW{1'b0}}}) &&
               (low_avg < {low_limit_q, {AlphaW{1'b0}}});
    warm_d   = warm_q;
    is_on_d  = is_on_q;
    go       = 1'b0;
    res_d.trans = TransNone;
    if (is_on_q) begin
      warm_d = warm_rld;
      if (high_avg < {off_thr_q, {AlphaW{1'b0}}}) begin
        is_on_d     = 1'b0;
        res_d.trans = TransOff;
      end
    end else if (!pass) begin
      warm_d = warm_rld;
    end else begin
      if (warm_en_q) begin
        if (warm_q > -1) begin
          warm_d = warm_q - WarmW'(1);
        end
        go = warm_d < 0;
      end else begin
        go = 1'b1;
      end
      if (go) begin
        is_on_d     = 1'b1;
        res_d.trans = TransOn;
      end
    end
    res_d.on = is_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_on_q <= 1'b0;
      warm_q  <= $signed(WarmW'(FramesRst));
    end else if (avg_vld && avg_vld_hi) begin
      is_on_q <= is_on_d;
      warm_q  <= warm_d;
    end
  end

  // Result queue and credit count for frames still in flight
  bed_res_t           res_mem [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0] cnt_q, pend_q;
  logic               res_wr, res_rd;
  logic [ResCntW:0]   used;

  assign res_wr = avg_vld && avg_vld_hi;
  assign res_rd = m_axis_tvalid && m_axis_tready;
  assign used   = (ResCntW + 1)'(cnt_q) + (ResCntW + 1)'(pend_q);

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_mem[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      pend_q   <= '0;
    end else begin
      if (res_wr) begin
        wr_ptr_q <= wr_ptr_q + ResPtrW'(1);
      end
      if (res_rd) begin
        rd_ptr_q <= rd_ptr_q + ResPtrW'(1);
      end
      cnt_q  <= cnt_q + ResCntW'(res_wr) - ResCntW'(res_rd);
      pend_q <= pend_q + ResCntW'(accept && s_axis_tlast) - ResCntW'(res_wr);
    end
  end

  // Drive the ports
  assign s_axis_tready = used < (ResCntW + 1)'(ResDepth);
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = OutDataW'(res_mem[rd_ptr_q]);

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for band_energy_hysteresis_detector_top.
// A scoreboard class predicts one status item per frame and checks the result stream.
// Depends on bed_pkg and the detector RTL.
`timescale 1ns / 1ps

import bed_pkg::*;

// Spare register indexes outside the register map; writes to them are dropped
localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

class frame_status_board;
  // Register copies
  logic [ThrW-1:0]    on_thr;
  logic [ThrW-1:0]    off_thr;
  logic [LimitW-1:0]  low_limit;
  logic [AlphaW-1:0]  alpha;
  logic               warm_en;
  logic [FramesW-1:0] warm_frames;
  // Detector state
  logic [LowAvgW-1:0]  low_avg;
  logic [HighAvgW-1:0] high_avg;
  logic [HighSumW-1:0] high_sum;
  logic [LowSmpW-1:0]  low_smp;
  int                  warm_left;
  logic                on_state;
  // Expected status items, oldest first
  bed_res_t            status_q[$];
  int                  errors;

  function new();
    on_thr      = '0;
    off_thr     = '0;
    low_limit   = LowLimitRst;
    alpha       = AlphaRst;
    warm_en     = WarmEnRst;
    warm_frames = FramesRst;
    low_avg     = '0;
    high_avg    = '0;
    high_sum    = '0;
    low_smp     = '0;
    warm_left   = int'(FramesRst);
    on_state    = 1'b0;
    errors      = 0;
  endfunction

  // Keep only the register's width of low bits; drop unlisted indexes
  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgOnThr:    on_thr      = data[ThrW-1:0];
      CfgOffThr:   off_thr     = data[ThrW-1:0];
      CfgLowLimit: low_limit   = data[LimitW-1:0];
      CfgAlpha:    alpha       = data[AlphaW-1:0];
      CfgWarmEn:   warm_en     = data[0];
      CfgWarmCnt:  warm_frames = data[FramesW-1:0];
      default: ;
    endcase
  endfunction

  // Moving average step: truncated decay plus exact new-value term, Q.16 result
  function logic [63:0] smooth(logic [63:0] avg, logic [63:0] smp);
    logic [63:0] a;
    logic [63:0] m;
    logic [63:0] decayed;
    a       = {48'd0, alpha};
    m       = 64'd65536 - a;
    decayed = (avg >> 16) * m + (({48'd0, avg[15:0]} * m) >> 16);
    return decayed + smp * a;
  endfunction

  // Fold one accepted bin into the frame; on the last bin predict the status item
  function void note_bin(logic [BinIdxW-1:0] idx, logic [PowerW-1:0] pwr, logic last);
    logic [HighSumW:0] sum;
    logic              pass;
    logic              go;
    bed_res_t          res;
    if (idx < FrameBinsDef) begin
      if (idx == 1) low_smp = pwr;
      if (idx >= BandFirstDef && idx < BandEndDef) begin
        sum      = high_sum + pwr;
        high_sum = sum[HighSumW] ? '1 : sum[HighSumW-1:0];
      end
    end
    if (!last) return;

    low_avg   = LowAvgW'(smooth({16'd0, low_avg}, {32'd0, low_smp}));
    high_avg  = HighAvgW'(smooth({10'd0, high_avg}, {26'd0, high_sum}));
    res.trans = TransNone;
    if (on_state) begin
      warm_left = int'(warm_frames);
      if (high_avg < {off_thr, 16'd0}) begin
        on_state  = 1'b0;
        res.trans = TransOff;
      end
    end else begin
      pass = (high_avg > {on_thr, 16'd0}) && (low_avg < {low_limit, 16'd0});
      if (!pass) begin
        warm_left = int'(warm_frames);
      end else begin
        go = 1'b1;
        if (warm_en) begin
          if (warm_left > -1) warm_left--;
          go = (warm_left < 0);
        end
        if (go) begin
          on_state  = 1'b1;
          res.trans = TransOn;
        end
      end
    end
    high_sum = '0;
    low_smp  = '0;
    res.on   = on_state;
    status_q.push_back(res);
  endfunction

  // Compare one accepted status item with the oldest expectation
  function void check_status(logic [OutDataW-1:0] data);
    bed_res_t exp_res;
    if (status_q.size() == 0) begin
      $error("status item 0x%0h arrived with no frame pending", data);
      errors++;
      return;
    end
    exp_res = status_q.pop_front();
    if (data[0] !== exp_res.on) begin
      $error("detector_on: expected %0d, got %0d", exp_res.on, data[0]);
      errors++;
    end
    if (data[2:1] !== exp_res.trans) begin
      $error("transition: expected %0d, got %0d", exp_res.trans, data[2:1]);
      errors++;
    end
    if (data[OutDataW-1:3] !== '0) begin
      $error("padding: expected 0, got 0x%0h", data[OutDataW-1:3]);
      errors++;
    end
  endfunction

  function int pending();
    return status_q.size();
  endfunction
endclass

module testbench;

  localparam int CycleLimit   = 300000;
  localparam int StallCycles  = 300;
  localparam int SettleCycles = 10;
  localparam int NumPhases    = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  // bin_index [7:0], bin_power [39:8]
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // detector_on [0], transition [2:1], zeros [7:3]
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  frame_status_board sb;
  bit                tx_fast;
  bit                rx_fast;
  bit                rx_hold;
  int                cycle_cnt;

  band_energy_hysteresis_detector_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one bin item after a random gap; return at the falling edge after acceptance
  task automatic send_bin(logic [BinIdxW-1:0] idx, logic [PowerW-1:0] pwr, logic last);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pwr, idx};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_bin(idx, pwr, last);
    @(negedge clk_i);
  endtask

  // Drive one register write; the caller drops the write enable afterwards
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every frame has reported and the pipeline is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One frame of random bins; loud frames carry strong high-band power
  task automatic send_frame(int n_bins, bit loud);
    int                  sel;
    logic [BinIdxW-1:0]  idx;
    logic [PowerW-1:0]   pwr;
    for (int i = 0; i < n_bins; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        idx = BinIdxW'($urandom_range(BandFirstDef, BandEndDef - 1));
        pwr = loud ? ($urandom | 32'h4000_0000) : $urandom_range(0, 32'h000F_FFFF);
      end else if (sel < 65) begin
        idx = 8'd1;
        pwr = $urandom;
      end else if (sel < 90) begin
        idx = BinIdxW'($urandom_range(0, 255));
        pwr = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: idx = 8'd0;
          1: idx = BinIdxW'(BandFirstDef - 1);
          2: idx = BinIdxW'(BandEndDef);
          default: idx = 8'd255;
        endcase
        pwr = $urandom;
      end
      send_bin(idx, pwr, i == n_bins - 1);
    end
  endtask

  // Random frames until about n_items bins have gone in
  task automatic run_frames(int n_items);
    int sent;
    int len;
    bit loud;
    sent = 0;
    loud = 1'($urandom_range(0, 1));
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) loud = !loud;
      tx_fast = ($urandom_range(0, 3) == 0);
      send_frame(len, loud);
      sent += len;
    end
  endtask

  // Load the register set of one phase and return its item budget
  task automatic program_phase(input int ph, output int n_items);
    logic [CfgDataW-1:0] on_v;
    logic [CfgDataW-1:0] off_v;
    logic [CfgDataW-1:0] lim_v;
    logic [CfgDataW-1:0] alpha_v;
    logic [CfgDataW-1:0] en_v;
    logic [CfgDataW-1:0] cnt_v;
    case (ph)
      0: begin
        on_v = 38'd1 << 32; off_v = 38'd1 << 28; lim_v = '1;
        alpha_v = 38'd65535; en_v = 38'd1; cnt_v = 38'd0; n_items = 50;
      end
      1: begin
        on_v = '0; off_v = '0; lim_v = '0;
        alpha_v = '0; en_v = '0; cnt_v = 38'd255; n_items = 25;
      end
      2: begin
        on_v = '1; off_v = '1; lim_v = '1;
        alpha_v = 38'd1; en_v = 38'd1; cnt_v = 38'd255; n_items = 40;
      end
      3: begin
        on_v = 38'd1 << 31; off_v = 38'd1 << 29; lim_v = {6'd0, 32'($urandom)};
        alpha_v = 38'd32768; en_v = '0; cnt_v = 38'd2; n_items = 50;
      end
      default: begin
        on_v    = (38'd1 << $urandom_range(28, 34)) + 38'($urandom_range(0, 65535));
        off_v   = on_v >> $urandom_range(0, 5);
        lim_v   = {6'($urandom), 32'($urandom)};
        alpha_v = {22'($urandom), 16'($urandom_range(1024, 65535))};
        en_v    = {6'($urandom), 32'($urandom)};
        cnt_v   = {30'($urandom), 8'($urandom_range(0, 4))};
        n_items = 45;
      end
    endcase
    write_reg(CfgOnThr, on_v);
    write_reg(CfgOffThr, off_v);
    write_reg(CfgLowLimit, lim_v);
    write_reg(CfgAlpha, alpha_v);
    write_reg(CfgWarmEn, en_v);
    write_reg(CfgWarmCnt, cnt_v);
    if (ph == 0) write_reg(CfgSpareLo, {6'($urandom), 32'($urandom)});
    if (ph >= 4) write_reg(CfgSpareHi, {6'($urandom), 32'($urandom)});
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random back-pressure, one long hold on request
  initial begin : result_sink
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold) begin
        rx_hold = 1'b0;
        gap     = StallCycles;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
        gap = rx_fast ? 0 : $urandom_range(0, 17);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_status(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int n_items;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    tx_fast       = 1'b0;
    rx_fast       = 1'b0;
    rx_hold       = 1'b0;
    cycle_cnt     = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames under reset settings: repeated low bin, band edges,
    // out-of-band bins, frames with missing bins, warm-up to turn-on
    send_bin(8'd1, 32'hFFFF_FFFF, 1'b0);
    send_bin(8'd1, 32'd5, 1'b0);
    send_bin(8'd64, 32'hFFFF_FFFF, 1'b0);
    send_bin(8'd127, 32'hFFFF_FFFF, 1'b0);
    send_bin(8'd0, 32'h0000_1234, 1'b0);
    send_bin(8'd128, 32'hFFFF_FFFF, 1'b0);
    send_bin(8'd63, 32'hFFFF_FFFF, 1'b0);
    send_bin(8'd255, 32'd0, 1'b1);
    send_bin(8'd100, 32'h8000_0000, 1'b1);
    send_bin(8'd200, 32'd0, 1'b1);
    send_bin(8'd65, 32'd1, 1'b1);
    send_bin(8'd2, 32'hAAAA_AAAA, 1'b0);
    send_bin(8'd96, 32'h5555_5555, 1'b1);
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      program_phase(ph, n_items);
      // Saturate the high-band sum with a long frame of full-scale bins
      if (ph == 0) begin
        tx_fast = 1'b1;
        for (int i = 0; i < 70; i++) send_bin(8'(BandFirstDef + i % 64), '1, i == 69);
      end
      // Hold the result side while short frames keep coming, to fill the queue
      if (ph == 3) begin
        rx_hold = 1'b1;
        tx_fast = 1'b1;
        for (int i = 0; i < 30; i++) send_bin(8'(BandFirstDef + i), $urandom, 1'b1);
      end
      run_frames(n_items);
      settle();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
